FILE: rtl/extremum_color_classifier_assert.svh
// ----------------------------------------------------------------------------
// Extremum color classifier assertion macros
// Concurrent assertion wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef EXTREMUM_COLOR_CLASSIFIER_ASSERT_SVH
`define EXTREMUM_COLOR_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted
`define ECC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset
`define ECC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define ECC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants of the extremum color classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SLOPE_W  = SAMPLE_W + 1;
    localparam int BEND_W   = SAMPLE_W + 2;
    localparam int CODE_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Black reference level loaded into the previous sample at reset
    localparam logic [SAMPLE_W-1:0] BLACK_REF = 12'd1228;

    // Threshold reset values
    localparam logic [SAMPLE_W-1:0] THR_BLACK_RST = 12'd1207;
    localparam logic [SAMPLE_W-1:0] THR_BLUE_RST  = 12'd1001;
    localparam logic [SAMPLE_W-1:0] THR_RED_RST   = 12'd791;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_THR_BLACK = 2'd0;
    localparam logic [1:0] REG_THR_BLUE  = 2'd1;
    localparam logic [1:0] REG_THR_RED   = 2'd2;

    typedef enum logic [CODE_W-1:0] {
        COLOR_BLUE  = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_WHITE = 2'd2,
        COLOR_BLACK = 2'd3
    } color_t;

    // Threshold set handed from the register file to the classifier
    typedef struct packed {
        logic [SAMPLE_W-1:0] black;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] red;
    } thr_t;

    // Classifier result for one transaction
    typedef struct packed {
        logic   emit;
        color_t code;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/extremum_color_classifier.sv
// Path of an accepted sample: input register, classifier, result register.
// Throughput: one sample per cycle while no result is stalled; the slope/color
// state loop closes through the classifier between input and result registers.
// The input register absorbs one sample while a result is stalled.
// Reset (rst_n, async, active low): thresholds 1207/1001/791, previous sample
// 1228, previous slope 0, color black, both stages empty.
// ----------------------------------------------------------------------------
// extremum_color_classifier
// Detects curve extrema in sensor samples and reports object color changes.
// ----------------------------------------------------------------------------
`default_nettype none

module extremum_color_classifier
    import ecc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    input  wire logic                sample_valid,
    output logic                     sample_stall,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic                     color_valid,
    input  wire logic                color_stall,
    output logic      [CODE_W-1:0]   color_code
);

    thr_t                thr;
    res_t                res;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                out_busy;
    logic                proc_go;
    logic                accept;

    ecc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    // Input stage advances unless a stalled result blocks the output
    assign proc_go      = s1_valid_reg && !out_busy;
    assign sample_stall = s1_valid_reg && out_busy;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (proc_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_sample_reg <= sample;
    end

    ecc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (proc_go),
        .sample_in (s1_sample_reg),
        .thr       (thr),
        .res       (res)
    );

    ecc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res.emit),
        .code_in (res.code),
        .stall   (color_stall),
        .valid   (color_valid),
        .code    (color_code),
        .busy    (out_busy)
    );

endmodule

`default_nettype wire

FILE: rtl/ecc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ecc_cfg_regs
// APB register file holding the three grading thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_cfg_regs
    import ecc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output thr_t                   thr
);

    thr_t        thr_reg;
    thr_t        thr_next;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // Write decode
    always_comb
    begin
        thr_next = thr_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_THR_BLACK: thr_next.black = pwdata[SAMPLE_W-1:0];
                REG_THR_BLUE:  thr_next.blue  = pwdata[SAMPLE_W-1:0];
                REG_THR_RED:   thr_next.red   = pwdata[SAMPLE_W-1:0];
                default:       thr_next       = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.black <= THR_BLACK_RST;
            thr_reg.blue  <= THR_BLUE_RST;
            thr_reg.red   <= THR_RED_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_THR_BLACK: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thr_reg.black};
            REG_THR_BLUE:  prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thr_reg.blue};
            REG_THR_RED:   prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thr_reg.red};
            default:       prdata = '0;
        endcase
    end

    assign thr = thr_reg;

endmodule

`default_nettype wire

FILE: rtl/ecc_classify.sv
// ----------------------------------------------------------------------------
// ecc_classify
// Slope tracking, extremum detection and color grading for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "extremum_color_classifier_assert.svh"

module ecc_classify
    import ecc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic [SAMPLE_W-1:0] sample_in,
    input  wire thr_t                thr,
    output res_t                     res
);

    logic [SAMPLE_W-1:0] prev_sample_reg;
    logic [SLOPE_W-1:0]  prev_slope_reg;
    color_t              color_reg;
    color_t              color_next;

    logic [SLOPE_W-1:0]  slope;
    logic [BEND_W-1:0]   bend;
    logic                rise;
    logic                fall;
    logic                prev_nonpos;
    logic                prev_nonneg;
    logic                bend_pos;
    logic                bend_neg;
    logic                at_min;
    logic                at_max;
    color_t              graded;

    // First and second differences, two's complement
    assign slope = {1'b0, sample_in} - {1'b0, prev_sample_reg};
    assign bend  = {slope[SLOPE_W-1], slope} - {prev_slope_reg[SLOPE_W-1], prev_slope_reg};

    assign rise        = !slope[SLOPE_W-1] && (slope != '0);
    assign fall        = slope[SLOPE_W-1];
    assign prev_nonpos = prev_slope_reg[SLOPE_W-1] || (prev_slope_reg == '0);
    assign prev_nonneg = !prev_slope_reg[SLOPE_W-1];
    assign bend_pos    = !bend[BEND_W-1] && (bend != '0);
    assign bend_neg    = bend[BEND_W-1];

    assign at_min = rise && prev_nonpos && bend_pos;
    assign at_max = fall && prev_nonneg && bend_neg;

    // Grade the previous sample; thresholds checked in fixed order
    always_comb
    begin
        priority if (prev_sample_reg > thr.black)
            graded = COLOR_BLACK;
        else if (!at_min)
            graded = color_reg;
        else if (prev_sample_reg > thr.blue)
            graded = COLOR_BLUE;
        else if (prev_sample_reg > thr.red)
            graded = COLOR_RED;
        else
            graded = COLOR_WHITE;
    end

    assign color_next = (at_min || at_max) ? graded : color_reg;

    // Report only a change to a non-black color
    assign res.emit = go && (color_next != color_reg) && (color_next != COLOR_BLACK);
    assign res.code = color_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= BLACK_REF;
            prev_slope_reg  <= '0;
            color_reg       <= COLOR_BLACK;
        end
        else if (go)
        begin
            prev_sample_reg <= sample_in;
            prev_slope_reg  <= slope;
            color_reg       <= color_next;
        end
    end

    // Checks
    `ECC_ASSERT(a_emit_not_black, clk, rst_n,
        res.emit |-> (res.code != COLOR_BLACK),
        "classifier reports black")
    `ECC_ASSERT(a_emit_is_change, clk, rst_n,
        res.emit |=> (color_reg == $past(res.code)),
        "reported color not stored as current color")
    `ECC_ASSERT(a_state_tracks_sample, clk, rst_n,
        go |=> (prev_sample_reg == $past(sample_in)),
        "previous sample not updated on processed transaction")

endmodule

`default_nettype wire

FILE: rtl/ecc_out_stage.sv
// ----------------------------------------------------------------------------
// ecc_out_stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_out_stage
    import ecc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [CODE_W-1:0] code_in,
    input  wire logic              stall,
    output logic                   valid,
    output logic      [CODE_W-1:0] code,
    output logic                   busy
);

    logic              valid_reg;
    logic              valid_next;
    logic [CODE_W-1:0] code_reg;

    // Held while a stalled result is pending
    assign busy = valid_reg && stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            code_reg <= code_in;
    end

    assign valid = valid_reg;
    assign code  = code_reg;

endmodule

`default_nettype wire
